// ----- rtl/assert_macros.svh -----
// Assertion macros for the scheduler RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/pts_pkg.sv -----
// Package for the periodic task scheduler: sizes, codes, payload, entry, state and memory request types.
// No dependencies.
package pts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam logic [1:0] MODE_CREATE   = 2'd0;
    localparam logic [1:0] MODE_DELETE   = 2'd1;
    localparam logic [1:0] MODE_TICK     = 2'd2;
    localparam logic [1:0] MODE_DISPATCH = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  task_id;
        logic [15:0] start_offset;
        logic [15:0] period;
        logic [7:0]  priority_req;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        dispatch_valid;
        logic [7:0]  run_id;
        logic [4:0]  task_total;
    } out_beat_t;

    // One table slot, held in service order.
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] start;
        logic [15:0] period;
        logic [7:0]  prio;
        logic [15:0] elapsed;
        logic        ready;
        logic        started;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PUT,
        S_DONE
    } state_t;

    // Memory access bundle from the sequencer to the table.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

endpackage

// ----- rtl/pts_table.sv -----
// Task table memory: one read port and one write port, registered read data.
// Depends on pts_pkg.
module pts_table (
    input  logic              clk,
    input  pts_pkg::mem_req_t req,
    output pts_pkg::entry_t   rd_data
);
    import pts_pkg::*;

    entry_t mem [MAX_TASKS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ----- rtl/pts_seq.sv -----
// Sequencer for the scheduler: walks the table for each command beat.
// Depends on pts_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pts_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  pts_pkg::in_beat_t   cmd,
    input  logic [15:0]         step,
    input  pts_pkg::entry_t     rd_data,
    output pts_pkg::mem_req_t   req,
    output logic                busy,
    output logic                done,
    output pts_pkg::out_beat_t  res
);
    import pts_pkg::*;

    state_t           state_reg, state_next;
    in_beat_t         cmd_reg, cmd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] k_reg, k_next;       // address being read
    logic             rv_reg, rv_next;     // read data valid for k_reg - 1 (for k_reg in a removal shift)
    logic [CNT_W-1:0] pos_reg, pos_next;   // found / insert position
    logic             hit_reg, hit_next;
    logic             rm_reg, rm_next;     // an entry is being removed
    out_beat_t        res_reg, res_next;

    logic [CNT_W-1:0] cur;
    entry_t           upd;

    assign cur = k_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            k_reg     <= '0;
            rv_reg    <= 1'b0;
            pos_reg   <= '0;
            hit_reg   <= 1'b0;
            rm_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            rv_reg    <= rv_next;
            pos_reg   <= pos_next;
            hit_reg   <= hit_next;
            rm_reg    <= rm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cmd_reg.mode == MODE_CREATE && count_reg == CNT_W'(MAX_TASKS))
                begin
                    state_next = S_DONE;
                end
                else if (rv_reg && (cmd_reg.mode == MODE_CREATE)
                         && rd_data.prio > cmd_reg.priority_req)
                begin
                    state_next = S_SHIFT;
                end
                else if (rv_reg && (cmd_reg.mode == MODE_DELETE)
                         && rd_data.id == cmd_reg.task_id)
                begin
                    state_next = S_SHIFT;
                end
                else if (rv_reg && (cmd_reg.mode == MODE_DISPATCH) && rd_data.ready)
                begin
                    state_next = (rd_data.period == 16'd0) ? S_SHIFT : S_DONE;
                end
                else if (k_reg == count_reg && (!rv_reg || cur == count_reg - CNT_W'(1)
                         || count_reg == '0))
                begin
                    if (rv_reg || count_reg == '0)
                    begin
                        state_next = (cmd_reg.mode == MODE_CREATE) ? S_PUT : S_DONE;
                    end
                end
            end
            S_SHIFT:
            begin
                if (cmd_reg.mode == MODE_CREATE)
                begin
                    if (k_reg == pos_reg && !rv_reg)
                    begin
                        state_next = S_PUT;
                    end
                end
                else if (k_reg == count_reg && !rv_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_PUT:    state_next = S_DONE;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        cmd_next   = cmd_reg;
        count_next = count_reg;
        k_next     = k_reg;
        rv_next    = 1'b0;
        pos_next   = pos_reg;
        hit_next   = hit_reg;
        rm_next    = rm_reg;
        res_next   = res_reg;
        req        = '0;
        upd        = rd_data;
        upd.elapsed = rd_data.elapsed + step;
        if ((rd_data.started ? rd_data.period : rd_data.start) == upd.elapsed)
        begin
            upd.ready = 1'b1;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_next = cmd;
                k_next   = '0;
                pos_next = '0;
                hit_next = 1'b0;
                rm_next  = 1'b0;
            end
            S_SCAN:
            begin
                // Issue the next read while the previous one returns.
                if (k_reg < count_reg)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = k_reg[IDX_W-1:0];
                    k_next      = k_reg + CNT_W'(1);
                    rv_next     = 1'b1;
                end
                if (state_next == S_SHIFT)
                begin
                    pos_next = cur;
                    hit_next = 1'b1;
                    rv_next  = 1'b0;
                    if (cmd_reg.mode == MODE_CREATE)
                    begin
                        // Shift upwards from the top entry down to pos.
                        k_next = count_reg;
                    end
                    else
                    begin
                        rm_next = 1'b1;
                        k_next  = cur + CNT_W'(1);
                        if (cmd_reg.mode == MODE_DISPATCH)
                        begin
                            res_next.run_id = rd_data.id;
                        end
                    end
                end
                else if (state_next == S_PUT)
                begin
                    pos_next = count_reg;
                end
                else if (state_next == S_DONE && rv_reg
                         && cmd_reg.mode == MODE_DISPATCH && rd_data.ready)
                begin
                    hit_next        = 1'b1;
                    res_next.run_id = rd_data.id;
                    req.wr_en       = 1'b1;
                    req.wr_addr     = cur[IDX_W-1:0];
                    req.wr_data     = rd_data;
                    req.wr_data.ready   = 1'b0;
                    req.wr_data.elapsed = 16'd0;
                    req.wr_data.started = 1'b1;
                end
                else if (rv_reg && cmd_reg.mode == MODE_TICK)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = cur[IDX_W-1:0];
                    req.wr_data = upd;
                end
            end
            S_SHIFT:
            begin
                if (cmd_reg.mode == MODE_CREATE)
                begin
                    // Read k-1, then write it to k.
                    if (rv_reg)
                    begin
                        req.wr_en   = 1'b1;
                        req.wr_addr = k_reg[IDX_W-1:0];
                        req.wr_data = rd_data;
                    end
                    else if (k_reg != pos_reg)
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = IDX_W'(k_reg - CNT_W'(1));
                        rv_next     = 1'b1;
                    end
                    if (rv_reg)
                    begin
                        k_next = k_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    // Read k, then write it to k-1.
                    if (rv_reg)
                    begin
                        req.wr_en   = 1'b1;
                        req.wr_addr = IDX_W'(k_reg - CNT_W'(1));
                        req.wr_data = rd_data;
                        k_next      = k_reg + CNT_W'(1);
                    end
                    else if (k_reg < count_reg)
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = k_reg[IDX_W-1:0];
                        rv_next     = 1'b1;
                    end
                end
            end
            S_PUT:
            begin
                req.wr_en           = 1'b1;
                req.wr_addr         = pos_reg[IDX_W-1:0];
                req.wr_data.id      = cmd_reg.task_id;
                req.wr_data.start   = cmd_reg.start_offset;
                req.wr_data.period  = cmd_reg.period;
                req.wr_data.prio    = cmd_reg.priority_req;
                req.wr_data.elapsed = 16'd0;
                req.wr_data.ready   = (cmd_reg.start_offset == 16'd0);
                req.wr_data.started = 1'b0;
                hit_next            = 1'b1;
            end
            S_DONE:
            begin
                res_next.dispatch_valid = 1'b0;
                res_next.status         = ST_OK;
                case (cmd_reg.mode)
                    MODE_CREATE:
                    begin
                        if (!hit_reg)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (!hit_reg)
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                    end
                    MODE_DISPATCH:
                    begin
                        if (!hit_reg)
                        begin
                            res_next.status = ST_NONE;
                        end
                        res_next.dispatch_valid = hit_reg;
                    end
                    default: ;
                endcase
                if (!(cmd_reg.mode == MODE_DISPATCH && hit_reg))
                begin
                    res_next.run_id = 8'd0;
                end
                if (rm_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                res_next.task_total = 5'(count_next);
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign res  = res_next;

    `ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_TASKS))
    `ASSERT_IMP(a_rm_not_create, clk, rst_n, rm_reg, cmd_reg.mode != MODE_CREATE)
    `ASSERT_NXT(a_done_idle, clk, rst_n, state_reg == S_DONE, state_reg == S_IDLE)

endmodule

// ----- rtl/periodic_task_scheduler_top.sv -----
// Top level of the periodic task scheduler: handshakes, tick step register, result register.
// Depends on pts_pkg, pts_table and pts_seq.
//
// The scheduler holds up to sixteen tasks in a table with one read and one write port, kept
// in service order (ascending priority, then creation order), and takes one command beat at a
// time. Each beat walks the table through the memory's registered read port: a tick reads and
// rewrites every held entry; create and delete shift the entries above the insertion or
// removal point one read and one write at a time; dispatch scans until the first ready task.
// The result beat sits in an output register, and a new command is only taken once that
// register is empty or is handing its beat over in the same cycle, so a stalled result holds
// off the input. The user must write tick_step through cfg_we/cfg_data only while no command
// is in flight; the block does not enforce this. tick_step resets to one.
module periodic_task_scheduler_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  pts_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output pts_pkg::out_beat_t out_data
);
    import pts_pkg::*;

    logic [15:0] step_reg;
    logic        out_valid_reg;
    out_beat_t   out_data_reg;
    mem_req_t    req;
    entry_t      rd_data;
    logic        busy, done, go;
    out_beat_t   res;

    // A command is accepted when the sequencer is idle and the result register is empty or
    // hands its beat over at the same edge, so completion always finds the register free.
    assign in_stall = busy || (out_valid_reg && out_stall);
    assign go       = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 16'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_reg <= cfg_data;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    pts_table u_table (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    pts_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .cmd     (in_data),
        .step    (step_reg),
        .rd_data (rd_data),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .res     (res)
    );

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the periodic task scheduler: random and directed command beats,
// with a predictor of the task table. Depends on pts_pkg and periodic_task_scheduler_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pts_pkg::*;

    typedef struct {
        logic [7:0]  id;
        logic [15:0] start;
        logic [15:0] period;
        logic [7:0]  prio;
        logic [15:0] elapsed;
        logic        ready;
        logic        started;
    } task_slot_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_data = 16'd0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_beat_t out_data;

    // The predictor's copy of the table, kept in service order.
    task_slot_t sched_table[MAX_TASKS];
    int unsigned sched_count = 0;
    logic [15:0] sched_step = 16'd1;

    in_beat_t pending_cmds[$];
    out_beat_t expected_results[$];
    int error_count = 0;
    int hold_cycles = 0;
    bit gaps_on = 1'b1;
    int idle_left = 0;
    int stall_left = 0;
    bit in_taken = 1'b0;

    periodic_task_scheduler_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        #100ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic void drop_slot(int pos);
        for (int k = pos; k + 1 < sched_count; k++)
            sched_table[k] = sched_table[k + 1];
        sched_count--;
    endfunction

    // Applies one command to the table copy and returns the result the block should give.
    function automatic out_beat_t schedule_step(in_beat_t cmd);
        out_beat_t res;
        int pos;
        logic [15:0] target;
        res = '0;
        case (cmd.mode)
            MODE_CREATE:
            begin
                if (sched_count >= MAX_TASKS)
                    res.status = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < sched_count && sched_table[pos].prio <= cmd.priority_req)
                        pos++;
                    for (int k = sched_count; k > pos; k--)
                        sched_table[k] = sched_table[k - 1];
                    sched_table[pos] = '{cmd.task_id, cmd.start_offset, cmd.period,
                                         cmd.priority_req, 16'd0, cmd.start_offset == 0, 1'b0};
                    sched_count++;
                end
            end
            MODE_DELETE:
            begin
                res.status = ST_NOT_FOUND;
                for (int k = 0; k < sched_count; k++)
                begin
                    if (sched_table[k].id == cmd.task_id)
                    begin
                        drop_slot(k);
                        res.status = ST_OK;
                        break;
                    end
                end
            end
            MODE_TICK:
            begin
                for (int k = 0; k < sched_count; k++)
                begin
                    sched_table[k].elapsed = sched_table[k].elapsed + sched_step;
                    target = sched_table[k].started ? sched_table[k].period
                                                    : sched_table[k].start;
                    if (sched_table[k].elapsed == target)
                        sched_table[k].ready = 1'b1;
                end
            end
            default:
            begin
                res.status = ST_NONE;
                for (int k = 0; k < sched_count; k++)
                begin
                    if (sched_table[k].ready)
                    begin
                        res.status = ST_OK;
                        res.dispatch_valid = 1'b1;
                        res.run_id = sched_table[k].id;
                        sched_table[k].ready = 1'b0;
                        sched_table[k].elapsed = 16'd0;
                        sched_table[k].started = 1'b1;
                        if (sched_table[k].period == 16'd0)
                            drop_slot(k);
                        break;
                    end
                end
            end
        endcase
        res.task_total = sched_count[4:0];
        return res;
    endfunction

    function automatic int gap_length();
        if (!gaps_on || $urandom_range(0, 2) == 0)
            return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // Input acceptance is seen at the rising edge, where each beat is predicted as it is taken.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            expected_results.push_back(schedule_step(in_data));
            void'(pending_cmds.pop_front());
            in_taken = 1'b1;
        end
    end

    // Driver: presents the head of the queue once the previous beat has been taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
                idle_left = gap_length();
            if (!in_valid || in_taken)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_cmds[0];
                end
                else
                    in_valid <= 1'b0;
            end
            in_taken = 1'b0;
        end
    end

    // Receiver stalls: random gaps, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left = gap_length();
            out_stall <= 1'b0;
        end
    end

    // Monitor: compares each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result beat", 1, 0);
            else
            begin
                out_beat_t want;
                want = expected_results.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch("status", out_data.status, want.status);
                if (out_data.dispatch_valid !== want.dispatch_valid)
                    report_mismatch("dispatch_valid", out_data.dispatch_valid,
                                    want.dispatch_valid);
                if (out_data.run_id !== want.run_id)
                    report_mismatch("run_id", out_data.run_id, want.run_id);
                if (out_data.task_total !== want.task_total)
                    report_mismatch("task_total", out_data.task_total, want.task_total);
            end
        end
    end

    function automatic in_beat_t make_cmd(logic [1:0] m, logic [7:0] id, logic [15:0] st,
                                          logic [15:0] per, logic [7:0] pr);
        in_beat_t c;
        c.mode = m;
        c.task_id = id;
        c.start_offset = st;
        c.period = per;
        c.priority_req = pr;
        return c;
    endfunction

    // A random beat, weighted towards ticks and dispatches on a small id space so that
    // deletes hit and tasks become ready; offsets and periods are mostly short.
    function automatic in_beat_t random_cmd(logic [15:0] step);
        int pick;
        logic [15:0] st;
        logic [15:0] per;
        pick = $urandom_range(0, 99);
        st = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6) * step);
        per = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5) * step);
        return make_cmd(pick < 20 ? MODE_CREATE : pick < 30 ? MODE_DELETE :
                        pick < 65 ? MODE_TICK : MODE_DISPATCH,
                        ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
                        st, per,
                        ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_step(logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sched_step = value;
    endtask

    initial
    begin
        logic [15:0] steps[5];
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table cases, ready-at-once, wrap, full table and ties.
        pending_cmds.push_back(make_cmd(MODE_DISPATCH, 8'd0, 16'd0, 16'd0, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_DELETE, 8'd5, 16'd0, 16'd0, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_TICK, 8'd0, 16'd0, 16'd0, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_CREATE, 8'hFF, 16'd0, 16'd0, 8'hFF));
        pending_cmds.push_back(make_cmd(MODE_CREATE, 8'd1, 16'd0, 16'd2, 8'hFF));
        pending_cmds.push_back(make_cmd(MODE_DISPATCH, 8'd0, 16'd0, 16'd0, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_TICK, 8'd0, 16'd0, 16'd0, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_TICK, 8'd0, 16'd0, 16'd0, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_DISPATCH, 8'd0, 16'd0, 16'd0, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_DISPATCH, 8'd0, 16'd0, 16'd0, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_CREATE, 8'd2, 16'hFFFF, 16'hFFFF, 8'd0));
        for (int k = 0; k < 15; k++)
            pending_cmds.push_back(make_cmd(MODE_CREATE, 8'd9, 16'd3, 16'd0, 8'd7));
        pending_cmds.push_back(make_cmd(MODE_CREATE, 8'hAA, 16'h5555, 16'hAAAA, 8'h55));
        pending_cmds.push_back(make_cmd(MODE_DELETE, 8'd9, 16'd0, 16'd0, 8'd0));
        wait_drained();

        // Phases under several step sizes, extremes included; the last one holds off
        // the receiver long enough for the block to fill and stall its input.
        steps = '{16'd0, 16'hFFFF, 16'd3, 16'h8000, 16'd1};
        foreach (steps[p])
        begin
            write_step(steps[p]);
            for (int k = 0; k < 265; k++)
                pending_cmds.push_back(random_cmd(steps[p] == 0 ? 16'd1 : steps[p]));
            if (p == 4)
            begin
                gaps_on = 1'b0;
                hold_cycles = 300;
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_table.sv
rtl/pts_seq.sv
rtl/periodic_task_scheduler_top.sv
bench/testbench.sv
